@@ rtl/thfd_pkg.sv @@
// Shared types, constants and the CRC-8 step function for the frame decoder.
package thfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int RAW_W    = 16;
  localparam int OFFSET_W = 11;
  localparam int TEMP_W   = 15;
  localparam int HUM_W    = 14;
  localparam int SUM_W    = 16;

  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -11'sd400;

  // Scale factors and bounds, hundredths of a unit
  localparam logic [14:0] TEMP_SPAN = 15'd17500;
  localparam logic [13:0] HUM_SPAN  = 14'd10000;
  localparam logic signed [SUM_W-1:0] TEMP_BIAS = 16'sd4500;
  localparam logic signed [SUM_W-1:0] TEMP_MIN  = -16'sd5500;
  localparam logic signed [SUM_W-1:0] TEMP_MAX  = 16'sd13999;

  typedef logic [2:0] pos_t;

  // Byte positions within a frame
  localparam pos_t POS_TEMP_HI  = 3'd0;
  localparam pos_t POS_TEMP_LO  = 3'd1;
  localparam pos_t POS_TEMP_CRC = 3'd2;
  localparam pos_t POS_HUM_HI   = 3'd3;
  localparam pos_t POS_HUM_LO   = 3'd4;
  localparam pos_t POS_HUM_CRC  = 3'd5;

  typedef struct packed {
    logic                     emit;
    logic signed [TEMP_W-1:0] temp_centi;
    logic [HUM_W-1:0]         hum_centi;
    logic                     temp_ok;
    logic                     hum_ok;
  } result_t;

  // One byte through the CRC-8 (poly 0x31, MSB first)
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/temp_humidity_frame_decoder.sv @@
// The sixth byte's transaction loads the input register; its result then enters the output register.
// Throughput: one byte per cycle; the input register and output register
// pass a byte each cycle unless the output stays stalled with a result held.
// Reset (synchronous, rst high): frame position to the first byte, CRC to 0xFF,
// held values and flags to zero, offset register to -400, both registers empty.
module temp_humidity_frame_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic signed [thfd_pkg::OFFSET_W-1:0] temp_offset_centi,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [thfd_pkg::BYTE_W-1:0]          rx_byte,
  input  logic                                 frame_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [thfd_pkg::TEMP_W-1:0]   temp_centi,
  output logic [thfd_pkg::HUM_W-1:0]           hum_centi,
  output logic                                 temp_ok,
  output logic                                 hum_ok
);
  import thfd_pkg::*;

  logic signed [OFFSET_W-1:0] offset;
  logic                       in_q_valid;
  logic [BYTE_W-1:0]          in_q_byte;
  logic                       in_q_start;
  logic                       out_free;
  logic                       process;
  logic                       in_accept;
  result_t                    result;

  // Offset register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      offset <= temp_offset_centi;
    end
  end

  // Handshake: process the held byte whenever the output slot can take a result
  assign out_free  = !out_valid || !out_stall;
  assign process   = in_q_valid && out_free;
  assign in_stall  = in_q_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (process) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q_byte  <= rx_byte;
      in_q_start <= frame_start;
    end
  end

  thfd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .process (process),
    .data    (in_q_byte),
    .start   (in_q_start),
    .offset  (offset),
    .result  (result)
  );

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.emit) begin
      temp_centi <= result.temp_centi;
      hum_centi  <= result.hum_centi;
      temp_ok    <= result.temp_ok;
      hum_ok     <= result.hum_ok;
    end
  end

endmodule

@@ rtl/thfd_scale.sv @@
// Fixed-point scaling of raw words to temperature and humidity.
module thfd_scale (
  input  logic [thfd_pkg::RAW_W-1:0]           raw,
  input  logic signed [thfd_pkg::OFFSET_W-1:0] offset,
  output logic signed [thfd_pkg::TEMP_W-1:0]   temp_scaled,
  output logic [thfd_pkg::HUM_W-1:0]           hum_scaled
);
  import thfd_pkg::*;

  logic [30:0]              temp_prod;
  logic [29:0]              hum_prod;
  logic signed [SUM_W-1:0]  temp_sum;
  logic signed [SUM_W-1:0]  temp_sat;

  // Multiply by the span, keep the integer part
  assign temp_prod = 31'(TEMP_SPAN) * 31'(raw);
  assign hum_prod  = 30'(HUM_SPAN) * 30'(raw);

  // Apply bias and calibration offset
  assign temp_sum = $signed({1'b0, temp_prod[30:16]}) - TEMP_BIAS
                  + $signed({{(SUM_W-OFFSET_W){offset[OFFSET_W-1]}}, offset});

  // Clamp to the output range
  always_comb begin
    if (temp_sum < TEMP_MIN) begin
      temp_sat = TEMP_MIN;
    end else if (temp_sum > TEMP_MAX) begin
      temp_sat = TEMP_MAX;
    end else begin
      temp_sat = temp_sum;
    end
  end

  assign temp_scaled = temp_sat[TEMP_W-1:0];
  assign hum_scaled  = hum_prod[29:16];

endmodule

@@ rtl/thfd_frame.sv @@
// Frame tracking, CRC check and held measurement values.
module thfd_frame (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 process,
  input  logic [thfd_pkg::BYTE_W-1:0]          data,
  input  logic                                 start,
  input  logic signed [thfd_pkg::OFFSET_W-1:0] offset,
  output thfd_pkg::result_t                    result
);
  import thfd_pkg::*;

  pos_t                     pos, pos_next;
  logic [BYTE_W-1:0]        crc, crc_next;
  logic [RAW_W-1:0]         raw, raw_next;
  logic                     temp_pass, temp_pass_next;
  logic signed [TEMP_W-1:0] held_temp, held_temp_next;
  logic [HUM_W-1:0]         held_hum, held_hum_next;

  pos_t                     pos_eff;
  logic [BYTE_W-1:0]        crc_eff;
  logic [BYTE_W-1:0]        crc_step;
  logic                     match;
  logic signed [TEMP_W-1:0] temp_scaled;
  logic [HUM_W-1:0]         hum_scaled;

  thfd_scale u_scale (
    .raw         (raw),
    .offset      (offset),
    .temp_scaled (temp_scaled),
    .hum_scaled  (hum_scaled)
  );

  // Restart the frame on the start flag
  assign pos_eff  = start ? POS_TEMP_HI : pos;
  assign crc_eff  = start ? CRC_INIT : crc;
  assign crc_step = crc8_update(crc_eff, data);
  assign match    = (crc_eff == data);

  // Advance the frame by one byte
  always_comb begin
    pos_next       = pos_eff;
    crc_next       = crc_eff;
    raw_next       = raw;
    temp_pass_next = temp_pass;
    held_temp_next = held_temp;
    held_hum_next  = held_hum;
    result         = '0;
    case (pos_eff)
      POS_TEMP_HI, POS_HUM_HI: begin
        crc_next = crc_step;
        raw_next = {data, raw[BYTE_W-1:0]};
        pos_next = pos_eff + 3'd1;
      end
      POS_TEMP_LO, POS_HUM_LO: begin
        crc_next = crc_step;
        raw_next = {raw[RAW_W-1:BYTE_W], data};
        pos_next = pos_eff + 3'd1;
      end
      POS_TEMP_CRC: begin
        if (match) begin
          held_temp_next = temp_scaled;
        end
        temp_pass_next = match;
        crc_next       = CRC_INIT;
        pos_next       = POS_HUM_HI;
      end
      default: begin
        if (match) begin
          held_hum_next = hum_scaled;
        end
        crc_next          = CRC_INIT;
        pos_next          = POS_TEMP_HI;
        result.emit       = 1'b1;
        result.temp_centi = held_temp;
        result.hum_centi  = match ? hum_scaled : held_hum;
        result.temp_ok    = temp_pass;
        result.hum_ok     = match;
      end
    endcase
    if (!process) begin
      result.emit = 1'b0;
    end
  end

  // Hold frame state between bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_TEMP_HI;
      crc       <= CRC_INIT;
      raw       <= '0;
      temp_pass <= 1'b0;
      held_temp <= '0;
      held_hum  <= '0;
    end else if (process) begin
      pos       <= pos_next;
      crc       <= crc_next;
      raw       <= raw_next;
      temp_pass <= temp_pass_next;
      held_temp <= held_temp_next;
      held_hum  <= held_hum_next;
    end
  end

endmodule

@@ rtl/thfd_checker.sv @@
// Port-level checks on the frame decoder, attached by bind.
module thfd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [thfd_pkg::TEMP_W-1:0] temp_centi,
  input logic [thfd_pkg::HUM_W-1:0]         hum_centi
);
  import thfd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Temperature stays within the clamped range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed({temp_centi[TEMP_W-1], temp_centi}) >= TEMP_MIN) &&
                  ($signed({temp_centi[TEMP_W-1], temp_centi}) <= TEMP_MAX))
    else $error("temperature out of range");

  // Humidity stays below full scale
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hum_centi <= 14'd9999)
    else $error("humidity out of range");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind temp_humidity_frame_decoder thfd_checker u_thfd_checker (.*);

@@ test/temp_humidity_frame_decoder_tb.sv @@
// Self-checking testbench for the temperature/humidity frame decoder.
module temp_humidity_frame_decoder_tb;
  import thfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
    logic                     temp_ok;
    logic                     hum_ok;
  } reading_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              start;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic signed [OFFSET_W-1:0] temp_offset_centi = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [BYTE_W-1:0]          rx_byte = '0;
  logic                       frame_start = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [TEMP_W-1:0]   temp_centi;
  logic [HUM_W-1:0]           hum_centi;
  logic                       temp_ok;
  logic                       hum_ok;

  // Pending input bytes and readings still owed by the block
  frame_byte_t pending_bytes[$];
  reading_t    expected_readings[$];
  int          bytes_queued = 0;
  int          mismatches = 0;
  bit          calm = 1'b0;

  // Decoder state as the block should hold it
  pos_t                       frame_pos;
  logic [BYTE_W-1:0]          frame_crc;
  logic [RAW_W-1:0]           word_acc;
  logic                       temp_word_good;
  logic signed [TEMP_W-1:0]   last_temp;
  logic [HUM_W-1:0]           last_hum;
  logic signed [OFFSET_W-1:0] offset_now;

  temp_humidity_frame_decoder DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .temp_offset_centi (temp_offset_centi),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .rx_byte           (rx_byte),
    .frame_start       (frame_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temp_centi        (temp_centi),
    .hum_centi         (hum_centi),
    .temp_ok           (temp_ok),
    .hum_ok            (hum_ok)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shift one byte through CRC-8, polynomial 0x31, MSB first
  function automatic logic [BYTE_W-1:0] crc_after_byte(input logic [BYTE_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] r;
    r = crc ^ data;
    repeat (BYTE_W) begin
      r = r[BYTE_W-1] ? ({r[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {r[BYTE_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] word_crc(input logic [RAW_W-1:0] w);
    return crc_after_byte(crc_after_byte(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advance the decoder state by one accepted byte; queue a reading on the last byte
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic start);
    reading_t r;
    int       t;
    bit       match;
    if (start) begin
      frame_pos = POS_TEMP_HI;
      frame_crc = CRC_INIT;
    end
    match = (frame_crc == b);
    case (frame_pos)
      POS_TEMP_HI, POS_HUM_HI: begin
        frame_crc = crc_after_byte(frame_crc, b);
        word_acc  = {b, 8'h00};
        frame_pos = frame_pos + 3'd1;
      end
      POS_TEMP_LO, POS_HUM_LO: begin
        frame_crc     = crc_after_byte(frame_crc, b);
        word_acc[7:0] = b;
        frame_pos     = frame_pos + 3'd1;
      end
      POS_TEMP_CRC: begin
        if (match) begin
          t = (17500 * int'(word_acc)) / 65536 - 4500 + int'(offset_now);
          if (t < int'(TEMP_MIN)) t = int'(TEMP_MIN);
          if (t > int'(TEMP_MAX)) t = int'(TEMP_MAX);
          last_temp = t[TEMP_W-1:0];
        end
        temp_word_good = match;
        frame_crc      = CRC_INIT;
        frame_pos      = POS_HUM_HI;
      end
      default: begin
        if (match) begin
          t        = (10000 * int'(word_acc)) / 65536;
          last_hum = t[HUM_W-1:0];
        end
        frame_crc = CRC_INIT;
        frame_pos = POS_TEMP_HI;
        r.temp    = last_temp;
        r.hum     = last_hum;
        r.temp_ok = temp_word_good;
        r.hum_ok  = match;
        expected_readings.push_back(r);
      end
    endcase
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic start);
    frame_byte_t fb;
    fb.data  = data;
    fb.start = start;
    pending_bytes.push_back(fb);
    bytes_queued++;
  endtask

  // Queue a six-byte frame; a bad check byte is the right one with some bits flipped
  task automatic queue_frame(input logic [RAW_W-1:0] t_raw, input logic [RAW_W-1:0] h_raw,
                             input bit t_good, input bit h_good, input logic start);
    logic [BYTE_W-1:0] t_crc;
    logic [BYTE_W-1:0] h_crc;
    t_crc = word_crc(t_raw) ^ (t_good ? 8'h00 : 8'($urandom_range(255, 1)));
    h_crc = word_crc(h_raw) ^ (h_good ? 8'h00 : 8'($urandom_range(255, 1)));
    queue_byte(t_raw[15:8], start);
    queue_byte(t_raw[7:0], 1'b0);
    queue_byte(t_crc, 1'b0);
    queue_byte(h_raw[15:8], 1'b0);
    queue_byte(h_raw[7:0], 1'b0);
    queue_byte(h_crc, 1'b0);
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames, some cut short, some stray bytes
  task automatic queue_random_traffic(input int n_bytes);
    int goal;
    int k;
    bit resync;
    goal   = bytes_queued + n_bytes;
    resync = 1'b0;
    while (bytes_queued < goal) begin
      k = $urandom_range(99);
      if (k < 70) begin
        queue_frame(pick_raw(), pick_raw(), $urandom_range(99) < 85, $urandom_range(99) < 85,
                    resync | 1'($urandom_range(1)));
        resync = 1'b0;
      end else if (k < 85) begin
        k = $urandom_range(5, 1);
        queue_byte(8'($urandom), 1'($urandom_range(1)));
        repeat (k - 1) queue_byte(8'($urandom), 1'b0);
        resync = 1'b1;
      end else begin
        queue_byte(8'($urandom), $urandom_range(3) == 0);
      end
    end
  endtask

  // Write the offset register while the block is idle
  task automatic write_offset(input logic signed [OFFSET_W-1:0] v);
    @(posedge clk);
    cfg_valid         <= 1'b1;
    temp_offset_centi <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    offset_now = v;
  endtask

  // Driver: present queued bytes, hold while stalled
  always @(posedge clk) begin
    bit took;
    if (rst) begin
      in_valid    <= 1'b0;
      rx_byte     <= '0;
      frame_start <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        decode_byte(rx_byte, frame_start);
        pending_bytes.delete(0);
      end
      if (!in_valid || took) begin
        if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
          in_valid    <= 1'b1;
          rx_byte     <= pending_bytes[0].data;
          frame_start <= pending_bytes[0].start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each reading transaction, stall at random and once for a long stretch
  always @(posedge clk) begin
    reading_t   got;
    reading_t   want;
    static int  readings_seen = 0;
    static int  hold_left = 0;
    static bit  hold_done = 1'b0;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        readings_seen++;
        got = '{temp_centi, hum_centi, temp_ok, hum_ok};
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, actual %p", $time, got);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (got.temp !== want.temp) begin
            $display("%0t: temp_centi expected %0d, actual %0d", $time, want.temp, got.temp);
            mismatches++;
          end
          if (got.hum !== want.hum) begin
            $display("%0t: hum_centi expected %0d, actual %0d", $time, want.hum, got.hum);
            mismatches++;
          end
          if (got.temp_ok !== want.temp_ok) begin
            $display("%0t: temp_ok expected %0b, actual %0b", $time, want.temp_ok, got.temp_ok);
            mismatches++;
          end
          if (got.hum_ok !== want.hum_ok) begin
            $display("%0t: hum_ok expected %0b, actual %0b", $time, want.hum_ok, got.hum_ok);
            mismatches++;
          end
        end
      end
      if (!hold_done && readings_seen >= 50) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 34);
      end
    end
  end

  // Sequence: reset, then phases at different offsets, each drained before the next
  initial begin
    offset_now     = OFFSET_RESET;
    frame_pos      = POS_TEMP_HI;
    frame_crc      = CRC_INIT;
    word_acc       = '0;
    temp_word_good = 1'b0;
    last_temp      = '0;
    last_hum       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: write_offset(11'sd1023);
        2: write_offset(-11'sd1024);
        3: write_offset(11'sd1000);
        4: write_offset(-11'sd1000);
        5: write_offset(OFFSET_W'($urandom));
        6: write_offset(11'sd0);
        default: ;
      endcase
      @(negedge clk);
      calm = (ph == 3);
      if (ph == 0) begin
        // Both checks fail before any good word: held values stay zero
        queue_frame(16'h6666, 16'h8000, 1'b0, 1'b0, 1'b1);
        // Drop a partial frame on a start flag
        queue_byte(8'h12, 1'b1);
        queue_byte(8'h34, 1'b0);
        queue_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // Frame begins without its start flag
        queue_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);
        queue_frame(16'h5A5A, 16'hA5A5, 1'b1, 1'b0, 1'b0);
      end
      queue_random_traffic(210);
      while (pending_bytes.size() != 0 || in_valid || expected_readings.size() != 0)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
